// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source text lexer
// Word layouts of both channels, token kinds, lexer modes and the bundle
// that carries one character's tokens from the front to the back.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Default configuration
  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int TEXT_LEN_DEF      = 65536;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Tokens one character can cause: close, symbol/error or flush, end
  localparam int NSLOT = 3;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int START_W = 16;
  localparam int OLEN_W  = 8;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

  // Characters with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  // Lexer modes
  typedef enum logic [2:0] {
    M_IDLE,
    M_IDENT,
    M_DIGITS,
    M_STRING,
    M_CHAR_OPEN,
    M_CHAR_ESC,
    M_CHAR_BODY
  } mode_t;

  // Input word
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_text;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] token_start;
    logic [OLEN_W-1:0]  token_length;
    logic               last_of_run;
  } out_word_t;

  // One token inside a bundle
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [OLEN_W-1:0]  length;
  } tok_t;

  // Tokens of one character, in emit order from slot 0 up
  typedef struct packed {
    tok_t [NSLOT-1:0] slot;
    logic [NSLOT-1:0] vld;
  } bundle_t;

endpackage

// ===== design/stl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front: character classifier and lexer state
// Takes one character per cycle while take is high, advances the open token
// and builds the bundle of tokens the character closes, emits or flushes.
// ----------------------------------------------------------------------------
module stl_front
  import stl_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int TEXT_LEN      = TEXT_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_word_t word,
  output bundle_t  bundle,
  output logic     bundle_push
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int POS_W = $clog2(TEXT_LEN);

  mode_t             mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic [CHAR_W-1:0] c;
  logic              fresh;
  logic [LEN_W-1:0]  grown;
  logic [POS_W-1:0]  pos_inc;

  function automatic logic is_space(input logic [CHAR_W-1:0] ch);
    return ch inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
    return ch inside {[CH_DIG_0:CH_DIG_9]};
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] ch);
    return ch inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
  endfunction

  function automatic logic is_symbol(input logic [CHAR_W-1:0] ch);
    return ch inside {CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SEMI};
  endfunction

  // saturating length step
  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] len);
    return (len >= LEN_W'(MAX_TOKEN_LEN)) ? LEN_W'(MAX_TOKEN_LEN) : len + LEN_W'(1);
  endfunction

  function automatic tok_t make_tok(input logic [KIND_W-1:0] kind,
                                    input logic [POS_W-1:0]  start,
                                    input logic [LEN_W-1:0]  len);
    tok_t t;
    t.kind   = kind;
    t.start  = START_W'(start);
    t.length = (32'(len) > 32'd255) ? 8'hFF : OLEN_W'(len);
    return t;
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // lexing step
  always_comb begin
    c         = word.character;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    fresh     = 1'b0;
    grown     = grow(len_r);
    pos_inc   = (pos_r == POS_W'(TEXT_LEN - 1)) ? '0 : pos_r + POS_W'(1);
    bundle    = '0;

    if (take) begin
      // advance or close the open token
      case (mode_r)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            len_nxt = grown;
          end else begin
            bundle.slot[0] = make_tok(KIND_IDENT, start_r, len_r);
            bundle.vld[0]  = 1'b1;
            mode_nxt       = M_IDLE;
            len_nxt        = '0;
            fresh          = 1'b1;
          end
        end
        M_DIGITS: begin
          if (is_digit(c)) begin
            len_nxt = grown;
          end else begin
            bundle.slot[0] = make_tok(KIND_VALUE, start_r, len_r);
            bundle.vld[0]  = 1'b1;
            mode_nxt       = M_IDLE;
            len_nxt        = '0;
            fresh          = 1'b1;
          end
        end
        M_STRING: begin
          len_nxt = grown;
          if (c == CH_DQUOTE) begin
            bundle.slot[0] = make_tok(KIND_VALUE, start_r, grown);
            bundle.vld[0]  = 1'b1;
            mode_nxt       = M_IDLE;
            len_nxt        = '0;
          end
        end
        M_CHAR_OPEN: begin
          len_nxt  = grown;
          mode_nxt = (c == CH_BSLASH) ? M_CHAR_ESC : M_CHAR_BODY;
        end
        M_CHAR_ESC: begin
          len_nxt  = grown;
          mode_nxt = M_CHAR_BODY;
        end
        M_CHAR_BODY: begin
          // closing quote ends the literal, anything else breaks it
          if (c == CH_SQUOTE) begin
            bundle.slot[0] = make_tok(KIND_VALUE, start_r, grown);
          end else begin
            bundle.slot[0] = make_tok(KIND_ERROR, start_r, len_r);
            fresh          = 1'b1;
          end
          bundle.vld[0] = 1'b1;
          mode_nxt      = M_IDLE;
          len_nxt       = '0;
        end
        default: begin
          mode_nxt = M_IDLE;
          fresh    = 1'b1;
        end
      endcase

      // lex the character from idle
      if (fresh && !is_space(c)) begin
        if (is_symbol(c)) begin
          bundle.slot[1] = make_tok(KIND_SYMBOL, pos_r, LEN_W'(1));
          bundle.vld[1]  = 1'b1;
        end else if (is_letter(c) || is_digit(c) || c == CH_DQUOTE || c == CH_SQUOTE) begin
          start_nxt = pos_r;
          len_nxt   = LEN_W'(1);
          if (is_letter(c))       mode_nxt = M_IDENT;
          else if (is_digit(c))   mode_nxt = M_DIGITS;
          else if (c == CH_DQUOTE) mode_nxt = M_STRING;
          else                    mode_nxt = M_CHAR_OPEN;
        end else begin
          bundle.slot[1] = make_tok(KIND_ERROR, pos_r, LEN_W'(1));
          bundle.vld[1]  = 1'b1;
        end
      end

      pos_nxt = pos_inc;

      // end of text: flush, end token, back to the start
      if (word.end_of_text) begin
        if (mode_nxt != M_IDLE) begin
          bundle.slot[1] = make_tok((mode_nxt == M_IDENT)  ? KIND_IDENT :
                                    (mode_nxt == M_DIGITS) ? KIND_VALUE : KIND_ERROR,
                                    start_nxt, len_nxt);
          bundle.vld[1]  = 1'b1;
        end
        bundle.slot[2] = make_tok(KIND_END, pos_inc, '0);
        bundle.vld[2]  = 1'b1;
        mode_nxt       = M_IDLE;
        len_nxt        = '0;
        start_nxt      = '0;
        pos_nxt        = '0;
      end
    end

    bundle_push = take && (|bundle.vld);
  end

endmodule

// ===== design/stl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue: bundle queue between front and back
// Small circular queue so the classifier and the token serializer can
// stall on their own.
// ----------------------------------------------------------------------------
module stl_queue
  import stl_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  bundle_t wr_data,
  input  logic    rd_en,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t           mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    do_wr      = wr_en && !full;
    do_rd      = rd_en && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/stl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back: token serializer and output register
// Unpacks one bundle into single result words, one per cycle while the
// consumer keeps popping, and holds the oldest word for the consumer.
// ----------------------------------------------------------------------------
module stl_back
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  bundle_t   q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_word_t out_word
);

  bundle_t          work_r, work_nxt;
  logic [NSLOT-1:0] mask_r, mask_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_word_t        out_r, out_nxt;

  logic             out_take, emit;
  logic [1:0]       sel;
  logic [NSLOT-1:0] sel_bit, mask_left, mask_after;
  tok_t             sel_tok;

  assign empty    = !out_vld_r;
  assign out_word = out_r;

  always_comb begin
    // lowest pending slot goes first
    if (mask_r[0])      sel = 2'd0;
    else if (mask_r[1]) sel = 2'd1;
    else                sel = 2'd2;
    sel_bit    = NSLOT'(1) << sel;
    sel_tok    = work_r.slot[sel];
    mask_left  = mask_r & ~sel_bit;

    out_take   = !out_vld_r || pop;
    emit       = out_take && (|mask_r);
    mask_after = emit ? mask_left : mask_r;

    // refill the work register once it drains
    q_pop    = (mask_after == '0) && !q_empty;
    work_nxt = q_pop ? q_data : work_r;
    mask_nxt = q_pop ? q_data.vld : mask_after;

    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !pop;
    if (emit) begin
      out_nxt.token_kind   = sel_tok.kind;
      out_nxt.token_start  = sel_tok.start;
      out_nxt.token_length = sel_tok.length;
      out_nxt.last_of_run  = (mask_left == '0);
      out_vld_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      mask_r    <= mask_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== design/source_text_lexer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_lexer_unit: streaming lexical tokenizer
// One text character per word in; tokens with kind, start offset and length
// out, in text order.
//
//   channel | ports                         | word
//   input   | push, full, in_word           | character, end_of_text
//   result  | empty, pop, out_word          | kind, start, length, last_of_run
//
// A character is taken every cycle while push is high and full is low; the
// front lexes it in that cycle. Tokens leave at one per cycle, while pop keeps
// up, through the serializer's output register, so a character that causes
// several tokens holds the result side while they leave. A token passes the
// queue, the serializer's work register and its output register in turn.
// Reset is synchronous and clears lexer state, queue and output register.
// ----------------------------------------------------------------------------
module source_text_lexer_unit
  import stl_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int TEXT_LEN      = TEXT_LEN_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_word_t  in_word,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  logic    take;
  bundle_t f_bundle, q_bundle;
  logic    f_push, q_full, q_empty, q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  // classify and lex
  stl_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .TEXT_LEN     (TEXT_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .word       (in_word),
    .bundle     (f_bundle),
    .bundle_push(f_push)
  );

  // decoupling queue
  stl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_push),
    .wr_data(f_bundle),
    .rd_en  (q_pop),
    .rd_data(q_bundle),
    .full   (q_full),
    .empty  (q_empty)
  );

  // serialize tokens
  stl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_bundle),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_word(out_word)
  );

  // front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full)
    else $error("bundle written into full queue");

  // end token closes the run and has no length
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.token_kind == KIND_END) |->
      (out_word.token_length == '0 && out_word.last_of_run))
    else $error("malformed end token");

  // symbols are one character long
  a_symbol_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.token_kind == KIND_SYMBOL) |-> (out_word.token_length == 8'd1))
    else $error("symbol token with wrong length");

  // serializer only pulls a bundle when one is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of source_text_lexer_unit
// Feeds texts one character per word and predicts every token with a
// software lexer that keeps its own copy of the lexer state. Tokens are
// checked in order, field by field. A short directed text set comes first:
// all symbols, closing by a following character, char literals (plain,
// escaped, broken), unhandled bytes and an open string at end of text.
// Random texts made of mostly well-formed pieces follow.
// ----------------------------------------------------------------------------
module tb;
  import stl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Software lexer and the queue of tokens it expects
  class lexer_scoreboard;
    mode_t       lex_mode;
    int unsigned open_len;
    int unsigned open_start;
    int unsigned text_pos;
    out_word_t   token_q[$];
    int          errors;

    function new();
      lex_mode   = M_IDLE;
      open_len   = 0;
      open_start = 0;
      text_pos   = 0;
      errors     = 0;
    endfunction

    function bit is_letter(logic [CHAR_W-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function bit is_digit(logic [CHAR_W-1:0] c);
      return c >= CH_DIG_0 && c <= CH_DIG_9;
    endfunction

    function void add_token(logic [KIND_W-1:0] kind, int unsigned start,
                            int unsigned len);
      out_word_t t;
      t.token_kind   = kind;
      t.token_start  = START_W'(start);
      t.token_length = (len > 255) ? 8'd255 : OLEN_W'(len);
      t.last_of_run  = 1'b0;
      token_q.push_back(t);
    endfunction

    function void grow_open();
      open_len = (open_len >= MAX_TOKEN_LEN_DEF) ? MAX_TOKEN_LEN_DEF : open_len + 1;
    endfunction

    function void open_at(mode_t m, int unsigned pos);
      lex_mode   = m;
      open_start = pos;
      open_len   = 1;
    endfunction

    function void close_open(logic [KIND_W-1:0] kind);
      add_token(kind, open_start, open_len);
      lex_mode = M_IDLE;
      open_len = 0;
    endfunction

    // Character seen with no token open
    function void lex_fresh(logic [CHAR_W-1:0] c, int unsigned pos);
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        return;
      end
      if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
          c == CH_RPAREN || c == CH_SEMI) begin
        add_token(KIND_SYMBOL, pos, 1);
      end else if (is_letter(c)) begin
        open_at(M_IDENT, pos);
      end else if (is_digit(c)) begin
        open_at(M_DIGITS, pos);
      end else if (c == CH_DQUOTE) begin
        open_at(M_STRING, pos);
      end else if (c == CH_SQUOTE) begin
        open_at(M_CHAR_OPEN, pos);
      end else begin
        add_token(KIND_ERROR, pos, 1);
      end
    endfunction

    // Accepted input word: append the tokens it causes
    function void note_char(in_word_t w);
      logic [CHAR_W-1:0] c;
      int unsigned       pos;
      bit                fresh;
      int                first;
      c     = w.character;
      pos   = text_pos;
      fresh = 1'b0;
      first = token_q.size();
      case (lex_mode)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) grow_open();
          else begin
            close_open(KIND_IDENT);
            fresh = 1'b1;
          end
        end
        M_DIGITS: begin
          if (is_digit(c)) grow_open();
          else begin
            close_open(KIND_VALUE);
            fresh = 1'b1;
          end
        end
        M_STRING: begin
          grow_open();
          if (c == CH_DQUOTE) close_open(KIND_VALUE);
        end
        M_CHAR_OPEN: begin
          grow_open();
          lex_mode = (c == CH_BSLASH) ? M_CHAR_ESC : M_CHAR_BODY;
        end
        M_CHAR_ESC: begin
          grow_open();
          lex_mode = M_CHAR_BODY;
        end
        M_CHAR_BODY: begin
          if (c == CH_SQUOTE) begin
            grow_open();
            close_open(KIND_VALUE);
          end else begin
            close_open(KIND_ERROR);
            fresh = 1'b1;
          end
        end
        default: begin
          lex_mode = M_IDLE;
          fresh    = 1'b1;
        end
      endcase
      if (fresh) lex_fresh(c, pos);
      text_pos = (pos + 1) % TEXT_LEN_DEF;

      // End of text: flush, end token, back to the start
      if (w.end_of_text) begin
        case (lex_mode)
          M_IDLE: ;
          M_IDENT: close_open(KIND_IDENT);
          M_DIGITS: close_open(KIND_VALUE);
          default: close_open(KIND_ERROR);
        endcase
        add_token(KIND_END, text_pos, 0);
        lex_mode   = M_IDLE;
        open_len   = 0;
        open_start = 0;
        text_pos   = 0;
      end
      if (token_q.size() > first) token_q[token_q.size()-1].last_of_run = 1'b1;
    endfunction

    function bit field_ok(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: token %s mismatch: expected %0d, actual %0d",
                 $time, name, exp_v, got_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Accepted result word: compare with the oldest expected token
    function void check_token(out_word_t got);
      out_word_t exp_t;
      bit        ok;
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, actual kind %0d start %0d len %0d",
                 $time, got.token_kind, got.token_start, got.token_length);
        return;
      end
      exp_t = token_q.pop_front();
      ok = field_ok("kind", 32'(exp_t.token_kind), 32'(got.token_kind)) &
           field_ok("start", 32'(exp_t.token_start), 32'(got.token_start)) &
           field_ok("length", 32'(exp_t.token_length), 32'(got.token_length)) &
           field_ok("last_of_run", 32'(exp_t.last_of_run), 32'(got.last_of_run));
      if (!ok) errors++;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;

  lexer_scoreboard   sb;
  logic [CHAR_W-1:0] text_buf[$];
  bit                quiet = 1'b0;
  int                items_sent = 0;
  int                texts_sent = 0;
  int                idle_cycles = 0;

  source_text_lexer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  always #1 clk = ~clk;

  // Result side: random stalls, none during the quiet stretch
  always @(negedge clk) begin
    pop <= rst_n && (quiet || $urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_token(out_word);
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // One character word; called and returning at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_word.character   = c;
    in_word.end_of_text = eot;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_char(in_word);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && i == s.len() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    texts_sent++;
  endtask

  // Hold the input until every expected token has come out
  task automatic wait_drained();
    push = 1'b0;
    while (sb.token_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? CH_UP_A + CHAR_W'($urandom_range(0, 25))
                                       : CH_LO_A + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CH_DIG_0 + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + CHAR_W'(r);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_other(logic [CHAR_W-1:0] not_this);
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(0, 255)); while (b == not_this);
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_word_char();
    return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
  endfunction

  // Append one lexical piece to the text under construction
  task automatic add_piece();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = $urandom_range(0, 6);
    if (r < 22) begin
      text_buf.push_back(rand_letter());
      repeat (n) text_buf.push_back(rand_word_char());
    end else if (r < 36) begin
      repeat (n + 1) text_buf.push_back(rand_digit());
    end else if (r < 48) begin
      repeat (n % 3 + 1) text_buf.push_back(rand_blank());
    end else if (r < 62) begin
      case ($urandom_range(0, 4))
        0: text_buf.push_back(CH_LBRACE);
        1: text_buf.push_back(CH_RBRACE);
        2: text_buf.push_back(CH_LPAREN);
        3: text_buf.push_back(CH_RPAREN);
        default: text_buf.push_back(CH_SEMI);
      endcase
    end else if (r < 72) begin
      text_buf.push_back(CH_DQUOTE);
      repeat (n) text_buf.push_back(rand_other(CH_DQUOTE));
      text_buf.push_back(CH_DQUOTE);
    end else if (r < 82) begin
      // char literal, plain or escaped
      text_buf.push_back(CH_SQUOTE);
      if ($urandom_range(0, 1) != 0) begin
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
        text_buf.push_back(rand_other(CH_BSLASH));
      end
      text_buf.push_back(CH_SQUOTE);
    end else if (r < 90) begin
      text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      // broken or open literals
      case ($urandom_range(0, 3))
        0: begin
          text_buf.push_back(CH_SQUOTE);
          text_buf.push_back(rand_other(CH_BSLASH));
          text_buf.push_back(rand_other(CH_SQUOTE));
        end
        1: begin
          text_buf.push_back(CH_SQUOTE);
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(CHAR_W'($urandom_range(0, 255)));
          text_buf.push_back(rand_other(CH_SQUOTE));
        end
        2: begin
          text_buf.push_back(CH_DQUOTE);
          repeat (n) text_buf.push_back(rand_other(CH_DQUOTE));
        end
        default: text_buf.push_back(CH_SQUOTE);
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed texts
    send_str("x9{ 7a}", 1'b1);
    send_str("'\\'''z'()", 1'b1);
    send_str("'ab", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_str(";\"s", 1'b1);
    wait_drained();

    // Random texts, with a stretch where neither side idles
    while (items_sent < 290) begin
      quiet = (items_sent > 120 && items_sent < 200);
      repeat ($urandom_range(1, 8)) add_piece();
      send_text();
      if (texts_sent % 10 == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.token_q.size() != 0) begin
      $display("%0t: %0d expected tokens never came out", $time, sb.token_q.size());
    end
    if (sb.errors == 0 && sb.token_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
